// ===== src/stack_register_machine_execute_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the stack register machine execute core
// Short forms for the concurrent checks at the end of the top level. Each
// macro samples on clk and is disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef STACK_REGISTER_MACHINE_EXECUTE_CORE_MACROS_SVH
`define STACK_REGISTER_MACHINE_EXECUTE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRMX_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRMX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/srmx_pkg.sv =====
// ----------------------------------------------------------------------------
// srmx_pkg
// Shared types and constants of the stack register machine execute core:
// item layouts, opcodes, status codes and call codes.
// ----------------------------------------------------------------------------
`default_nettype none

package srmx_pkg;

  // Fixed sizes of the machine.
  localparam int REG_COUNT         = 256;
  localparam int REG_IDX_W         = 8;
  localparam int WORD_W            = 32;
  localparam int PC_W              = 24;
  localparam int STACK_DEPTH_DFLT  = 64;
  localparam int ADV_W             = 3;

  // Program counter steps.
  localparam logic [ADV_W-1:0] PC_STEP_NONE  = 3'd0;
  localparam logic [ADV_W-1:0] PC_STEP_SHORT = 3'd4;
  localparam logic [ADV_W-1:0] PC_STEP_LONG  = 3'd5;

  // Opcodes.
  localparam logic [7:0] OP_MOV   = 8'd0;
  localparam logic [7:0] OP_ADD   = 8'd1;
  localparam logic [7:0] OP_SUB   = 8'd2;
  localparam logic [7:0] OP_AND   = 8'd3;
  localparam logic [7:0] OP_OR    = 8'd4;
  localparam logic [7:0] OP_XOR   = 8'd5;
  localparam logic [7:0] OP_STORE = 8'd6;
  localparam logic [7:0] OP_LOAD  = 8'd7;
  localparam logic [7:0] OP_ADR   = 8'd8;
  localparam logic [7:0] OP_PUSH  = 8'd9;
  localparam logic [7:0] OP_POP   = 8'd10;
  localparam logic [7:0] OP_INC   = 8'd11;
  localparam logic [7:0] OP_DEC   = 8'd12;
  localparam logic [7:0] OP_SYS   = 8'd255;

  // System call codes, taken from r1.
  localparam logic [WORD_W-1:0] CALL_HALT  = 32'd0;
  localparam logic [WORD_W-1:0] CALL_PRINT = 32'd1;
  localparam logic [WORD_W-1:0] CALL_READ  = 32'd2;

  // Registers that a system call reads at fixed places.
  localparam logic [REG_IDX_W-1:0] IDX_ZERO      = 8'd0;
  localparam logic [REG_IDX_W-1:0] IDX_CALL_CODE = 8'd1;
  localparam logic [REG_IDX_W-1:0] IDX_CALL_ADDR = 8'd2;
  localparam logic [REG_IDX_W-1:0] IDX_CALL_LEN  = 8'd3;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_HALT        = 3'd1,
    ST_BAD_OP      = 3'd2,
    ST_STACK_EMPTY = 3'd3,
    ST_PRINT       = 3'd4,
    ST_READ        = 3'd5,
    ST_BAD_CALL    = 3'd6
  } status_t;

  // One instruction item.
  typedef struct packed {
    logic        [7:0]        action;
    logic        [7:0]        byte_one;
    logic        [7:0]        byte_two;
    logic        [7:0]        byte_three;
    logic        [7:0]        byte_four;
    logic signed [WORD_W-1:0] load_word;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic        [2:0]           status;
    logic                        overflow_flag;
    logic        [PC_W-1:0]      next_pc;
    logic                        reg_write;
    logic        [REG_IDX_W-1:0] reg_index;
    logic signed [WORD_W-1:0]    reg_value;
    logic                        mem_store;
    logic        [PC_W-1:0]      mem_address;
    logic signed [WORD_W-1:0]    mem_value;
    logic signed [WORD_W-1:0]    call_address;
    logic signed [WORD_W-1:0]    call_length;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/srmx_stream_if.sv =====
// ----------------------------------------------------------------------------
// srmx_stream_if
// Valid/ready channel carrying one item per handshake. The source drives
// valid and payload, the sink drives ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface srmx_stream_if #(
  parameter type item_t = logic
);

  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ===== src/srmx_ram.sv =====
// ----------------------------------------------------------------------------
// srmx_ram
// Generic single-write, single-read RAM with a registered read port. The
// read data holds while rd_en is low.
// ----------------------------------------------------------------------------
`default_nettype none

module srmx_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; a read at the address being written returns the old data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/stack_register_machine_execute_core.sv =====
// ----------------------------------------------------------------------------
// stack_register_machine_execute_core
// Executes one instruction of a small register machine per item, with a
// 256-entry register file, a value stack and the program counter.
// ----------------------------------------------------------------------------
// Usage:
// The in channel takes one instruction item: opcode, four operand bytes and
// the memory word for a load. The out channel gives one result item per
// instruction: next pc, register write, store request, call report and status.
// An accepted item sits in the execute register while the register file and
// stack RAMs deliver their reads, and its result is then loaded into the
// output register. Throughput is one item per cycle while the receiver
// keeps taking results; the execute register and the output register let a
// new item in while a finished result still waits.
// When the receiver stalls, the result holds, the execute register fills,
// and then ready drops until the output register is taken.
// Reset clears the program counter, the halt flag, the stack fill count and
// the per-register valid bits, so every register reads as zero at once; no
// clearing pass is needed. Reads use two copies of the register file RAM, and
// the item ahead's write is forwarded to the one behind it.
// After a halt every item returns status halt with the held pc.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stack_register_machine_execute_core_macros.svh"

module stack_register_machine_execute_core
  import srmx_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DFLT
) (
  input wire logic   clk,
  input wire logic   rst,
  srmx_stream_if.sink   in,
  srmx_stream_if.source out
);

  localparam int SP_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FILL_W = $clog2(STACK_DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(STACK_DEPTH);
  localparam logic [FILL_W-1:0] FILL_ONE = FILL_W'(1);

  // Pipeline control.
  logic      e_valid;
  in_item_t  e_item;
  logic      out_valid;
  out_item_t out_item;
  logic      in_fire;
  logic      e_fire;

  // Architectural state.
  logic [PC_W-1:0]   program_counter;
  logic              halted;
  logic [FILL_W-1:0] fill;
  logic [REG_COUNT-1:0] rf_valid;
  logic [WORD_W-1:0] call_code;
  logic [WORD_W-1:0] call_addr;
  logic [WORD_W-1:0] call_len;

  // Most recent register and stack writes, for forwarding.
  logic                 lw_valid;
  logic [REG_IDX_W-1:0] lw_idx;
  logic [WORD_W-1:0]    lw_val;
  logic                 sw_valid;
  logic [SP_W-1:0]      sw_idx;
  logic [WORD_W-1:0]    sw_val;

  // RAM ports.
  logic [WORD_W-1:0] rf_a_data;
  logic [WORD_W-1:0] rf_b_data;
  logic [WORD_W-1:0] sp_rd_data;
  logic [FILL_W-1:0] sp_rd_fill;
  logic [SP_W-1:0]   sp_rd_addr;
  logic [SP_W-1:0]   pop_idx;

  // Execute results.
  out_item_t         res;
  logic [WORD_W-1:0] opnd_a;
  logic [WORD_W-1:0] opnd_b;
  logic [WORD_W-1:0] pop_val;
  logic [WORD_W-1:0] alu_val;
  logic [PC_W-1:0]   mem_addr;
  logic [ADV_W-1:0]  advance;
  logic              push_ok;
  logic [FILL_W-1:0] fill_next;
  logic              halted_next;

  // Handshake.
  assign e_fire      = e_valid && (!out_valid || out.ready);
  assign in.ready    = !e_valid || e_fire;
  assign in_fire     = in.valid && in.ready;
  assign out.valid   = out_valid;
  assign out.payload = out_item;

  // Register file, two read copies written together.
  srmx_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_a (
    .clk     (clk),
    .wr_en   (e_fire && res.reg_write),
    .wr_addr (res.reg_index),
    .wr_data (res.reg_value),
    .rd_en   (in_fire),
    .rd_addr (in.payload.byte_one),
    .rd_data (rf_a_data)
  );

  srmx_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_b (
    .clk     (clk),
    .wr_en   (e_fire && res.reg_write),
    .wr_addr (res.reg_index),
    .wr_data (res.reg_value),
    .rd_en   (in_fire),
    .rd_addr (in.payload.byte_two),
    .rd_data (rf_b_data)
  );

  // Stack read address: the top entry as the item ahead leaves the stack.
  assign sp_rd_fill = (e_fire ? fill_next : fill) - FILL_ONE;
  assign sp_rd_addr = sp_rd_fill[SP_W-1:0];

  srmx_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk     (clk),
    .wr_en   (e_fire && push_ok),
    .wr_addr (fill[SP_W-1:0]),
    .wr_data (opnd_a),
    .rd_en   (in_fire),
    .rd_addr (sp_rd_addr),
    .rd_data (sp_rd_data)
  );

  // Operand selection: forwarded write, then never-written as zero, then RAM.
  always_comb begin
    if (lw_valid && lw_idx == e_item.byte_one) begin
      opnd_a = lw_val;
    end else if (!rf_valid[e_item.byte_one]) begin
      opnd_a = '0;
    end else begin
      opnd_a = rf_a_data;
    end
    if (lw_valid && lw_idx == e_item.byte_two) begin
      opnd_b = lw_val;
    end else if (!rf_valid[e_item.byte_two]) begin
      opnd_b = '0;
    end else begin
      opnd_b = rf_b_data;
    end
  end

  // Popped value, with the push of the item ahead forwarded.
  assign pop_idx = SP_W'(fill - FILL_ONE);
  assign pop_val = (sw_valid && sw_idx == pop_idx) ? sw_val : sp_rd_data;

  assign mem_addr = {e_item.byte_two, e_item.byte_three, e_item.byte_four};

  // Move-immediate and two-operand operations.
  always_comb begin
    case (e_item.action)
      OP_MOV:  alu_val = {16'd0, e_item.byte_one, e_item.byte_two};
      OP_ADD:  alu_val = opnd_a + opnd_b;
      OP_SUB:  alu_val = opnd_a - opnd_b;
      OP_AND:  alu_val = opnd_a & opnd_b;
      OP_OR:   alu_val = opnd_a | opnd_b;
      default: alu_val = opnd_a ^ opnd_b;
    endcase
  end

  // Instruction execute.
  always_comb begin
    res         = '0;
    res.status  = ST_OK;
    advance     = PC_STEP_SHORT;
    push_ok     = 1'b0;
    fill_next   = fill;
    halted_next = halted;
    if (halted) begin
      res.status = ST_HALT;
      advance    = PC_STEP_NONE;
    end else begin
      case (e_item.action) inside
        OP_MOV, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR: begin
          res.reg_write = 1'b1;
          res.reg_index = e_item.byte_three;
          res.reg_value = (e_item.byte_three == IDX_ZERO) ? '0 : alu_val;
        end
        OP_STORE: begin
          res.mem_store   = 1'b1;
          res.mem_address = mem_addr;
          res.mem_value   = opnd_a;
          advance         = PC_STEP_LONG;
        end
        OP_LOAD: begin
          res.reg_write   = 1'b1;
          res.reg_index   = e_item.byte_one;
          res.reg_value   = (e_item.byte_one == IDX_ZERO) ? '0 : e_item.load_word;
          res.mem_address = mem_addr;
          advance         = PC_STEP_LONG;
        end
        OP_ADR: begin
          res.reg_write = 1'b1;
          res.reg_index = e_item.byte_one;
          res.reg_value = (e_item.byte_one == IDX_ZERO) ? '0 : {8'd0, mem_addr};
          advance       = PC_STEP_LONG;
        end
        OP_PUSH: begin
          if (fill < FILL_MAX) begin
            push_ok   = 1'b1;
            fill_next = fill + FILL_ONE;
          end else begin
            res.overflow_flag = 1'b1;
          end
        end
        OP_POP: begin
          if (fill == '0) begin
            res.status  = ST_STACK_EMPTY;
            advance     = PC_STEP_NONE;
            halted_next = 1'b1;
          end else begin
            fill_next     = fill - FILL_ONE;
            res.reg_write = 1'b1;
            res.reg_index = e_item.byte_one;
            res.reg_value = (e_item.byte_one == IDX_ZERO) ? '0 : pop_val;
          end
        end
        OP_INC, OP_DEC: begin
          res.reg_write = 1'b1;
          res.reg_index = e_item.byte_one;
          res.reg_value = (e_item.action == OP_INC) ? opnd_a + 32'd1 : opnd_a - 32'd1;
        end
        OP_SYS: begin
          if (call_code == CALL_HALT) begin
            res.status  = ST_HALT;
            advance     = PC_STEP_NONE;
            halted_next = 1'b1;
          end else if (call_code == CALL_PRINT || call_code == CALL_READ) begin
            res.status       = (call_code == CALL_PRINT) ? ST_PRINT : ST_READ;
            res.call_address = call_addr;
            res.call_length  = call_len;
          end else begin
            res.status = ST_BAD_CALL;
          end
        end
        default: begin
          res.status  = ST_BAD_OP;
          advance     = PC_STEP_NONE;
          halted_next = 1'b1;
        end
      endcase
    end
    res.next_pc = program_counter + PC_W'(advance);
  end

  // Execute register.
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (in_fire) begin
      e_valid <= 1'b1;
    end else if (e_fire) begin
      e_valid <= 1'b0;
    end
    if (in_fire) begin
      e_item <= in.payload;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (e_fire) begin
      out_valid <= 1'b1;
    end else if (out.ready) begin
      out_valid <= 1'b0;
    end
    if (e_fire) begin
      out_item <= res;
    end
  end

  // Machine state commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      program_counter <= '0;
      halted          <= 1'b0;
      fill            <= '0;
      rf_valid        <= '0;
      call_code       <= '0;
      call_addr       <= '0;
      call_len        <= '0;
      lw_valid        <= 1'b0;
      sw_valid        <= 1'b0;
    end else if (e_fire) begin
      program_counter <= res.next_pc;
      halted          <= halted_next;
      fill            <= fill_next;
      if (res.reg_write) begin
        rf_valid[res.reg_index] <= 1'b1;
        lw_valid                <= 1'b1;
        if (res.reg_index == IDX_CALL_CODE) begin
          call_code <= res.reg_value;
        end
        if (res.reg_index == IDX_CALL_ADDR) begin
          call_addr <= res.reg_value;
        end
        if (res.reg_index == IDX_CALL_LEN) begin
          call_len <= res.reg_value;
        end
      end
      if (push_ok) begin
        sw_valid <= 1'b1;
      end
    end
  end

  // Forwarding payload of the latest writes.
  always_ff @(posedge clk) begin
    if (e_fire && res.reg_write) begin
      lw_idx <= res.reg_index;
      lw_val <= res.reg_value;
    end
    if (e_fire && push_ok) begin
      sw_idx <= fill[SP_W-1:0];
      sw_val <= opnd_a;
    end
  end

  // Checks.
  `SRMX_ASSERT_SAME(a_fill_bound, 1'b1, fill <= FILL_MAX, "stack fill beyond depth")
  `SRMX_ASSERT_NEXT(a_halt_holds_pc, halted, $stable(program_counter) && halted, "pc moved after halt")
  `SRMX_ASSERT_NEXT(a_halt_sets, e_fire && (res.status == ST_BAD_OP || res.status == ST_STACK_EMPTY), halted, "halting status did not halt")
  `SRMX_ASSERT_SAME(a_ovf_full, e_fire && res.overflow_flag, fill == FILL_MAX, "overflow with room on the stack")

endmodule

`default_nettype wire
